@@ design/wsm_pkg.sv @@
// ----------------------------------------------------------------------------
// wsm_pkg: shared types and constants of the windowed sample mean block
// Sizes, request codes, the queued request record and the result record.
// ----------------------------------------------------------------------------
package wsm_pkg;

    // Window geometry
    localparam int CHANNELS    = 2;
    localparam int WINDOW      = 100;
    localparam int SAMPLE_BITS = 12;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int CH_W     = 1;
    localparam int SMP_W    = 12;
    localparam int MEAN_W   = 20;
    localparam int FRAC_W   = 8;
    localparam int POS_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int DVD_W    = SUM_W + FRAC_W;
    localparam int STEP_W   = $clog2(DVD_W + 1);
    localparam int ADDR_W   = CH_W + POS_W;
    localparam int MEM_DEPTH = CHANNELS << POS_W;

    // Request queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_MEAN  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_kind_t;

    typedef struct packed {
        req_kind_t              kind;
        logic [CH_W-1:0]        ch;
        logic [SAMPLE_BITS-1:0] sample;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_CLEAR,
        S_MEAN,
        S_DIV,
        S_RESULT
    } back_state_t;

endpackage

@@ design/wsm_front.sv @@
// ----------------------------------------------------------------------------
// wsm_front: request intake
// Classifies incoming requests and forwards the meaningful ones to the queue.
// Unused request codes and out-of-range channels are taken and dropped.
// ----------------------------------------------------------------------------
module wsm_front (
    input  logic                        push,
    input  logic                        full,
    input  logic [wsm_pkg::REQ_W-1:0]   req_type,
    input  logic [wsm_pkg::CH_W-1:0]    channel,
    input  logic [wsm_pkg::SMP_W-1:0]   sample,
    output logic                        q_push,
    output wsm_pkg::req_t               q_entry
);
    import wsm_pkg::*;

    logic code_ok;
    logic chan_ok;

    // Classify the request
    always_comb
    begin
        code_ok = (req_type == REQ_PUSH) || (req_type == REQ_MEAN) ||
                  (req_type == REQ_CLEAR);
        chan_ok = (int'(channel) < CHANNELS);
    end

    // Build the queue entry; keep only the low sample bits
    always_comb
    begin
        q_entry.kind   = req_kind_t'(req_type);
        q_entry.ch     = channel;
        q_entry.sample = sample[SAMPLE_BITS-1:0];
        q_push         = push && !full && code_ok && chan_ok;
    end

endmodule

@@ design/wsm_queue.sv @@
// ----------------------------------------------------------------------------
// wsm_queue: request queue
// Short first-in first-out buffer that decouples intake from execution.
// ----------------------------------------------------------------------------
module wsm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  wsm_pkg::req_t wr_data,
    input  logic          rd_en,
    output wsm_pkg::req_t rd_data,
    output logic          full,
    output logic          empty
);
    import wsm_pkg::*;

    req_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + QCNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ design/wsm_div.sv @@
// ----------------------------------------------------------------------------
// wsm_div: iterative divider
// Restoring division, one quotient bit per cycle; the dividend register
// shifts out dividend bits and shifts in quotient bits.
// ----------------------------------------------------------------------------
module wsm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wsm_pkg::DVD_W-1:0]    dividend,
    input  logic [wsm_pkg::CNT_W-1:0]    divisor,
    output logic                         busy,
    output logic [wsm_pkg::MEAN_W-1:0]   quotient
);
    import wsm_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic [CNT_W-1:0]  rem_next;

    assign busy     = (step_reg != '0);
    assign quotient = dvd_reg[MEAN_W-1:0];

    // One trial subtraction
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, dsr_reg});
        if (q_bit)
            rem_next = CNT_W'(rem_sh - {1'b0, dsr_reg});
        else
            rem_next = rem_sh[CNT_W-1:0];
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (start)
            step_reg <= STEP_W'(DVD_W);
        else if (busy)
            step_reg <= step_reg - STEP_W'(1);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

endmodule

@@ design/wsm_back.sv @@
// ----------------------------------------------------------------------------
// wsm_back: request execution
// Holds the sample ring memory and per-channel position, count and sum.
// Runs push, clear and mean requests and holds the result for the consumer.
// ----------------------------------------------------------------------------
module wsm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  wsm_pkg::req_t q_head,
    output logic          q_pop,
    input  logic          pop,
    output logic          res_valid,
    output wsm_pkg::res_t res
);
    import wsm_pkg::*;

    back_state_t       state_reg, state_next;
    req_t              op_reg, op_next;
    logic [POS_W-1:0]  pos_reg [CHANNELS];
    logic [POS_W-1:0]  pos_next [CHANNELS];
    logic [CNT_W-1:0]  cnt_reg [CHANNELS];
    logic [CNT_W-1:0]  cnt_next [CHANNELS];
    logic [SUM_W-1:0]  sum_reg [CHANNELS];
    logic [SUM_W-1:0]  sum_next [CHANNELS];
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;

    logic                   div_start;
    logic                   div_busy;
    logic [MEAN_W-1:0]      div_quot;

    logic [POS_W-1:0]       cur_pos;
    logic [CNT_W-1:0]       cur_cnt;
    logic [SUM_W-1:0]       cur_sum;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign cur_pos  = pos_reg[op_reg.ch];
    assign cur_cnt  = cnt_reg[op_reg.ch];
    assign cur_sum  = sum_reg[op_reg.ch];
    assign mem_addr = {op_reg.ch, cur_pos};

    wsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({cur_sum, {FRAC_W{1'b0}}}),
        .divisor  (cur_cnt),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        div_start      = 1'b0;

        // Release the held result on a transfer
        if (pop && res_valid_reg)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop   = 1'b1;
                    op_next = q_head;
                    case (q_head.kind)
                        REQ_PUSH:  state_next = S_READ;
                        REQ_CLEAR: state_next = S_CLEAR;
                        REQ_MEAN:  state_next = S_MEAN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                // Fetch the oldest sample at the write position
                mem_re     = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (cur_cnt == CNT_W'(WINDOW))
                    sum_next[op_reg.ch] = cur_sum - SUM_W'(rd_data_reg)
                                          + SUM_W'(op_reg.sample);
                else
                begin
                    sum_next[op_reg.ch] = cur_sum + SUM_W'(op_reg.sample);
                    cnt_next[op_reg.ch] = cur_cnt + CNT_W'(1);
                end
                if (cur_pos == POS_W'(WINDOW - 1))
                    pos_next[op_reg.ch] = '0;
                else
                    pos_next[op_reg.ch] = cur_pos + POS_W'(1);
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                pos_next[op_reg.ch] = '0;
                cnt_next[op_reg.ch] = '0;
                sum_next[op_reg.ch] = '0;
                state_next          = S_IDLE;
            end
            S_MEAN:
            begin
                // Skip division for an empty window
                if (cur_cnt == '0)
                    state_next = S_RESULT;
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // Hold until the result register is free
                if (!res_valid_reg || pop)
                begin
                    res_valid_next    = 1'b1;
                    res_next.ch       = op_reg.ch;
                    res_next.count    = cur_cnt;
                    res_next.is_empty = (cur_cnt == '0);
                    res_next.mean     = (cur_cnt == '0) ? '0 : div_quot;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
                cnt_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    // Sample ring memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= op_reg.sample;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

endmodule

@@ design/windowed_sample_mean_top.sv @@
// ----------------------------------------------------------------------------
// windowed_sample_mean_top: per-channel sliding-window moving average
// Push, query and clear requests over a ring of recent samples per channel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         push / full         req_type, channel, sample
//  result    out        empty / pop         result_channel, mean_q8,
//                                           sample_count, is_empty
//
//  In the back end a push is a memory read, then write and update; a clear
//  zeroes the channel state; a mean query uses the divider, which retires one
//  quotient bit per cycle over a 27-bit dividend; an empty window skips it.
//  Reset empties every window; the ring memory itself is not cleared.
//  A four-entry request queue keeps taking requests while the back end works
//  or while a result waits; a query stalls only when that result is untaken.
// ----------------------------------------------------------------------------
module windowed_sample_mean_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [wsm_pkg::REQ_W-1:0]     req_type,
    input  logic [wsm_pkg::CH_W-1:0]      channel,
    input  logic [wsm_pkg::SMP_W-1:0]     sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [wsm_pkg::CH_W-1:0]      result_channel,
    output logic [wsm_pkg::MEAN_W-1:0]    mean_q8,
    output logic [wsm_pkg::CNT_W-1:0]     sample_count,
    output logic                          is_empty
);
    import wsm_pkg::*;

    logic q_push;
    req_t q_entry;
    logic q_pop;
    req_t q_head;
    logic q_empty;
    logic res_valid;
    res_t res;

    wsm_front u_front (
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .channel  (channel),
        .sample   (sample),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    wsm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (full),
        .empty   (q_empty)
    );

    wsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    // Drive the result ports
    assign empty          = !res_valid;
    assign result_channel = res.ch;
    assign mean_q8        = res.mean;
    assign sample_count   = res.count;
    assign is_empty       = res.is_empty;

endmodule

@@ tb/window_mean_checker.sv @@
// ----------------------------------------------------------------------------
// window_mean_checker: predicts and checks the windowed sample mean results
// Watches request and result transfers, keeps its own per-channel windows,
// queues the expected mean for each accepted query and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module window_mean_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic [wsm_pkg::REQ_W-1:0]    req_type,
    input  logic [wsm_pkg::CH_W-1:0]     channel,
    input  logic [wsm_pkg::SMP_W-1:0]    sample,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [wsm_pkg::CH_W-1:0]     result_channel,
    input  logic [wsm_pkg::MEAN_W-1:0]   mean_q8,
    input  logic [wsm_pkg::CNT_W-1:0]    sample_count,
    input  logic                         is_empty,
    output int                           mismatches,
    output int                           results_due
);
    import wsm_pkg::*;

    // Keep the log bounded when the block is badly broken
    localparam int MAX_REPORTS = 100;

    // Predicted window state per channel
    logic [SMP_W-1:0] ring_q  [CHANNELS][WINDOW];
    logic [POS_W-1:0] wr_pos  [CHANNELS];
    logic [CNT_W-1:0] held    [CHANNELS];
    logic [SUM_W-1:0] win_sum [CHANNELS];

    // Expected mean results, oldest first
    res_t means_due [$];
    res_t oldest;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Advance the predicted windows by one accepted request
    task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [CH_W-1:0] ch,
                                 input logic [SMP_W-1:0] smp);
        longint unsigned quot;
        res_t            due;
        if (int'(ch) < CHANNELS) begin
            case (kind)
                REQ_PUSH: begin
                    // drop the oldest sample once the ring is full
                    if (held[ch] >= CNT_W'(WINDOW))
                        win_sum[ch] = win_sum[ch] - SUM_W'(ring_q[ch][wr_pos[ch]]);
                    else
                        held[ch] = held[ch] + CNT_W'(1);
                    ring_q[ch][wr_pos[ch]] = smp;
                    win_sum[ch] = win_sum[ch] + SUM_W'(smp);
                    wr_pos[ch] = (wr_pos[ch] == POS_W'(WINDOW - 1)) ? '0
                                                                    : wr_pos[ch] + POS_W'(1);
                end
                REQ_MEAN: begin
                    quot = 0;
                    if (held[ch] != '0) begin
                        quot = 64'(win_sum[ch]);
                        quot = (quot << FRAC_W) / 64'(held[ch]);
                    end
                    due.ch       = ch;
                    due.mean     = quot[MEAN_W-1:0];
                    due.count    = held[ch];
                    due.is_empty = (held[ch] == '0);
                    means_due.push_back(due);
                end
                REQ_CLEAR: begin
                    wr_pos[ch]  = '0;
                    held[ch]    = '0;
                    win_sum[ch] = '0;
                end
                default: ;
            endcase
        end
    endtask

    // Check result transfers, then predict from request transfers
    always @(posedge clk) begin
        if (!rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                wr_pos[c]  = '0;
                held[c]    = '0;
                win_sum[c] = '0;
            end
            means_due.delete();
            mismatches = 0;
            results_due <= 0;
        end else begin
            if (pop && !empty) begin
                if (means_due.size() == 0) begin
                    report_mismatch($sformatf("result with none due: ch %0d mean %0d count %0d",
                                              result_channel, mean_q8, sample_count));
                end else begin
                    oldest = means_due.pop_front();
                    if (result_channel !== oldest.ch)
                        report_mismatch($sformatf("result_channel %0d, want %0d",
                                                  result_channel, oldest.ch));
                    if (mean_q8 !== oldest.mean)
                        report_mismatch($sformatf("mean_q8 %0d, want %0d (ch %0d)",
                                                  mean_q8, oldest.mean, oldest.ch));
                    if (sample_count !== oldest.count)
                        report_mismatch($sformatf("sample_count %0d, want %0d (ch %0d)",
                                                  sample_count, oldest.count, oldest.ch));
                    if (is_empty !== oldest.is_empty)
                        report_mismatch($sformatf("is_empty %0b, want %0b (ch %0d)",
                                                  is_empty, oldest.is_empty, oldest.ch));
                end
            end
            if (push && !full)
                apply_request(req_type, channel, sample);
            results_due <= means_due.size();
        end
    end

endmodule

@@ tb/windowed_sample_mean_top_tb.sv @@
// ----------------------------------------------------------------------------
// windowed_sample_mean_top_tb: request stimulus and verdict for the mean block
// Drives a directed opening and then random push / query / clear sequences
// under changing idle patterns and one long result hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module windowed_sample_mean_top_tb;
    import wsm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int TOTAL_REQUESTS = 1450;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 48;
    localparam int STALL_LIMIT    = 5000;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_ZERO,
        FILL_LOW,
        FILL_HIGH
    } fill_style_e;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [REQ_W-1:0]    req_type;
    logic [CH_W-1:0]     channel;
    logic [SMP_W-1:0]    sample;
    logic                empty;
    logic                pop;
    logic [CH_W-1:0]     result_channel;
    logic [MEAN_W-1:0]   mean_q8;
    logic [CNT_W-1:0]    sample_count;
    logic                is_empty;

    int                  mismatches;
    int                  results_due;
    int unsigned         sender_idle_pct;
    int unsigned         receiver_idle_pct;
    int                  requests_done;
    int                  stall_cycles;
    logic                hold_go;
    logic                hold_taken;

    windowed_sample_mean_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .channel        (channel),
        .sample         (sample),
        .empty          (empty),
        .pop            (pop),
        .result_channel (result_channel),
        .mean_q8        (mean_q8),
        .sample_count   (sample_count),
        .is_empty       (is_empty)
    );

    window_mean_checker mean_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .channel        (channel),
        .sample         (sample),
        .empty          (empty),
        .pop            (pop),
        .result_channel (result_channel),
        .mean_q8        (mean_q8),
        .sample_count   (sample_count),
        .is_empty       (is_empty),
        .mismatches     (mismatches),
        .results_due    (results_due)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Pick a sample value for one push of a burst
    function automatic logic [SMP_W-1:0] fill_value(input fill_style_e style);
        case (style)
            FILL_MAX:  fill_value = '1;
            FILL_ZERO: fill_value = '0;
            FILL_LOW:  fill_value = SMP_W'($urandom_range(15));
            FILL_HIGH: fill_value = SMP_W'($urandom_range(4095, 4032));
            default:   fill_value = SMP_W'($urandom_range(4095));
        endcase
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [CH_W-1:0] ch,
                                input logic [SMP_W-1:0] smp);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        req_type <= kind;
        channel  <= ch;
        sample   <= smp;
        do @(posedge clk); while (full);
        if (kind != REQ_UNUSED)
            requests_done++;
    endtask

    // Result side: random stalls plus one long hold-off
    initial
    begin
        pop = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n) begin
            stall_cycles <= 0;
        end else begin
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("windowed_sample_mean_top test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [CH_W-1:0]  ch;
        logic [REQ_W-1:0] kind;
        fill_style_e      style;
        int               pick;
        int               burst_len;

        rst_n             = 1'b0;
        push              = 1'b0;
        req_type          = REQ_PUSH;
        channel           = '0;
        sample            = '0;
        hold_go           = 1'b0;
        requests_done     = 0;
        sender_idle_pct   = 20;
        receiver_idle_pct = 61;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty windows, sample extremes, unused code, clear
        send_request(REQ_MEAN,   1'b0, 12'd0);
        send_request(REQ_MEAN,   1'b1, 12'hfff);
        send_request(REQ_PUSH,   1'b0, 12'hfff);
        send_request(REQ_PUSH,   1'b0, 12'h000);
        send_request(REQ_MEAN,   1'b0, 12'h000);
        send_request(REQ_PUSH,   1'b1, 12'hfff);
        send_request(REQ_MEAN,   1'b1, 12'h000);
        send_request(REQ_UNUSED, 1'b0, 12'hfff);
        send_request(REQ_MEAN,   1'b0, 12'hfff);
        send_request(REQ_CLEAR,  1'b0, 12'hfff);
        send_request(REQ_MEAN,   1'b0, 12'h000);
        send_request(REQ_PUSH,   1'b0, 12'd1);
        send_request(REQ_PUSH,   1'b0, 12'd2);
        send_request(REQ_MEAN,   1'b0, 12'h555);
        send_request(REQ_CLEAR,  1'b1, 12'h000);
        send_request(REQ_MEAN,   1'b1, 12'haaa);
        send_request(REQ_UNUSED, 1'b1, 12'haaa);
        send_request(REQ_PUSH,   1'b1, 12'h555);
        send_request(REQ_MEAN,   1'b1, 12'hfff);

        // Random sequences, mostly push bursts closed by a query
        while (requests_done < TOTAL_REQUESTS) begin
            if (requests_done < TOTAL_REQUESTS / 3) begin
                sender_idle_pct   = 20;
                receiver_idle_pct = 61;
            end else if (requests_done < 2 * TOTAL_REQUESTS / 3) begin
                sender_idle_pct   = 61;
                receiver_idle_pct = 20;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
                if (!hold_go) begin
                    // hold off the results while queries keep coming
                    hold_go = 1'b1;
                    repeat (PRESSURE_ITEMS) begin
                        kind = ($urandom_range(3) == 0) ? REQ_PUSH : REQ_MEAN;
                        send_request(kind, CH_W'($urandom_range(1)),
                                     SMP_W'($urandom_range(4095)));
                    end
                end
            end

            ch   = CH_W'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 65) begin
                style     = fill_style_e'($urandom_range(4));
                burst_len = ($urandom_range(9) == 0) ? $urandom_range(230, 100)
                                                     : $urandom_range(24, 1);
                for (int i = 0; i < burst_len; i++) begin
                    send_request(REQ_PUSH, ch, fill_value(style));
                    if ($urandom_range(3) == 0)
                        send_request(REQ_MEAN, CH_W'($urandom_range(1)),
                                     SMP_W'($urandom_range(4095)));
                end
                send_request(REQ_MEAN, ch, SMP_W'($urandom_range(4095)));
            end else if (pick < 78) begin
                send_request(REQ_CLEAR, ch, SMP_W'($urandom_range(4095)));
                send_request(REQ_MEAN, ch, SMP_W'($urandom_range(4095)));
            end else if (pick < 92) begin
                send_request(REQ_MEAN, ch, SMP_W'($urandom_range(4095)));
            end else if (pick < 96) begin
                send_request(REQ_UNUSED, ch, SMP_W'($urandom_range(4095)));
            end else begin
                send_request(REQ_CLEAR, ch, SMP_W'($urandom_range(4095)));
            end
        end
        push <= 1'b0;

        // Drain: wait for every due result, then for late extras
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && results_due == 0)
            $display("windowed_sample_mean_top test passed");
        else
            $display("windowed_sample_mean_top test failed");
        $finish;
    end

endmodule
